@@ hw/rtl/tle_pkg.sv @@
// Shared types and constants of the terminal line editor.
// No dependencies; compiled first.
package tle_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_CHAR   = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	// Received byte codes.
	localparam logic [7:0] KEY_BS        = 8'd8;
	localparam logic [7:0] KEY_LF        = 8'd10;
	localparam logic [7:0] KEY_CR        = 8'd13;
	localparam logic [7:0] KEY_ESC       = 8'h1B;
	localparam logic [7:0] KEY_DEL       = 8'd127;
	localparam logic [7:0] PRINT_LOW     = 8'd32;
	localparam logic [7:0] PRINT_HIGH    = 8'd126;
	localparam logic [7:0] CH_LBRACKET   = 8'h5B;
	localparam logic [7:0] CH_LEFT       = 8'h44;
	localparam logic [7:0] CH_RIGHT      = 8'h43;
	localparam logic [7:0] CH_THREE      = 8'h33;
	localparam logic [7:0] CH_TILDE      = 8'h7E;

	localparam logic [5:0] MAX_CHARS_RST = 6'd63;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_BRACKET,
		PH_THREE
	} tle_phase_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_STAT,
		ACT_EMPTY,
		ACT_DEL,
		ACT_INS,
		ACT_LINE
	} tle_act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FILL,
		ST_STAT,
		ST_LINE_RD,
		ST_LINE_LD
	} tle_state_t;

endpackage

@@ hw/rtl/tle_if.sv @@
// Valid/ready channel interfaces of the terminal line editor.
// Depends on nothing; compiled after tle_pkg.
interface tle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tle_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic [5:0] caret_pos;
	logic [5:0] line_len;
	logic       last;

	modport source (output valid, output kind, output char_out, output caret_pos,
		output line_len, output last, input ready);
	modport sink (input valid, input kind, input char_out, input caret_pos,
		input line_len, input last, output ready);
endinterface

@@ hw/rtl/tle_line_ram.sv @@
// Line store: one write port and one read port with registered read data.
// No dependencies.
module tle_line_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/terminal_line_editor_core.sv @@
// Top level of the terminal line editor.
// Depends on tle_pkg, tle_if and tle_line_ram.
//
// Takes one received byte at a time and keeps an editable line in a small memory with one
// write and one registered read port. A byte that yields no result is done once taken; a byte
// that only yields a status result then goes through ST_STAT. An insert or delete shifts the
// characters behind the cursor one per cycle through the memory ports in ST_SHIFT, an insert
// then writes the new byte in ST_FILL, and both end in ST_STAT. CR or LF reads the line back
// one character at a time, alternating ST_LINE_RD and ST_LINE_LD. Stalls on the result side
// hold ST_STAT and ST_LINE_LD. The block takes no new byte until the last result of the
// current one is loaded into the output register; that register holds a result while the
// next byte is accepted. The store needs no clearing after reset.
module terminal_line_editor_core #(
	parameter int LINE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	tle_rx_if.sink            rx_ch,
	tle_res_if.source         res_ch
);

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	tle_pkg::tle_state_t state_q, state_nxt;
	tle_pkg::tle_phase_t phase_q, dec_phase;
	tle_pkg::tle_act_t   dec_act;

	logic [5:0]    cursor_q, length_q, max_chars_q;
	logic [5:0]    dec_cursor, dec_length;
	logic [5:0]    n_q, left_q;
	logic [AW-1:0] src_q, dst_q, wpos_q, idx_q;
	logic          pend_q, ins_q, empty_q;
	logic [7:0]    byte_q;

	logic          out_valid_q, out_last_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_char_q;
	logic [5:0]    out_cursor_q, out_len_q;

	logic          accept, out_free, load_stat, load_char;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [7:0]    c;

	assign c        = rx_ch.rx_byte;
	assign accept   = rx_ch.valid && rx_ch.ready;
	assign out_free = !out_valid_q || res_ch.ready;

	// Byte decode: new escape phase, cursor and length, and the work to start.
	always_comb begin
		dec_phase  = phase_q;
		dec_cursor = cursor_q;
		dec_length = length_q;
		dec_act    = tle_pkg::ACT_NONE;
		case (phase_q)
			tle_pkg::PH_ESC: begin
				if (c == tle_pkg::CH_LBRACKET) begin
					dec_phase = tle_pkg::PH_BRACKET;
				end else begin
					dec_phase = tle_pkg::PH_IDLE;
					dec_act   = tle_pkg::ACT_STAT;
				end
			end
			tle_pkg::PH_BRACKET: begin
				if (c == tle_pkg::CH_THREE) begin
					dec_phase = tle_pkg::PH_THREE;
				end else begin
					if (c == tle_pkg::CH_LEFT && cursor_q != 6'd0) begin
						dec_cursor = cursor_q - 6'd1;
					end else if (c == tle_pkg::CH_RIGHT && cursor_q < length_q) begin
						dec_cursor = cursor_q + 6'd1;
					end
					dec_phase = tle_pkg::PH_IDLE;
					dec_act   = tle_pkg::ACT_STAT;
				end
			end
			tle_pkg::PH_THREE: begin
				dec_phase = tle_pkg::PH_IDLE;
				if (c == tle_pkg::CH_TILDE && cursor_q < length_q) begin
					dec_act    = tle_pkg::ACT_DEL;
					dec_length = length_q - 6'd1;
				end else begin
					dec_act = tle_pkg::ACT_STAT;
				end
			end
			default: begin
				if (c == tle_pkg::KEY_ESC) begin
					dec_phase = tle_pkg::PH_ESC;
				end else if (c == tle_pkg::KEY_BS || c == tle_pkg::KEY_DEL) begin
					if (cursor_q != 6'd0) begin
						dec_cursor = cursor_q - 6'd1;
						dec_length = length_q - 6'd1;
						dec_act    = tle_pkg::ACT_DEL;
					end else begin
						dec_act = tle_pkg::ACT_STAT;
					end
				end else if (c == tle_pkg::KEY_CR || c == tle_pkg::KEY_LF) begin
					dec_cursor = 6'd0;
					dec_length = 6'd0;
					dec_act    = (length_q == 6'd0) ? tle_pkg::ACT_EMPTY : tle_pkg::ACT_LINE;
				end else if (c >= tle_pkg::PRINT_LOW && c <= tle_pkg::PRINT_HIGH) begin
					if (length_q < max_chars_q && int'(length_q) < LINE_DEPTH) begin
						dec_cursor = cursor_q + 6'd1;
						dec_length = length_q + 6'd1;
						dec_act    = tle_pkg::ACT_INS;
					end
				end
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tle_pkg::ST_IDLE: begin
				if (accept) begin
					case (dec_act)
						tle_pkg::ACT_STAT, tle_pkg::ACT_EMPTY: state_nxt = tle_pkg::ST_STAT;
						tle_pkg::ACT_DEL, tle_pkg::ACT_INS:   state_nxt = tle_pkg::ST_SHIFT;
						tle_pkg::ACT_LINE:                     state_nxt = tle_pkg::ST_LINE_RD;
						default:                               state_nxt = tle_pkg::ST_IDLE;
					endcase
				end
			end
			tle_pkg::ST_SHIFT: begin
				if (n_q == 6'd0 && !pend_q) begin
					state_nxt = ins_q ? tle_pkg::ST_FILL : tle_pkg::ST_STAT;
				end
			end
			tle_pkg::ST_FILL:    state_nxt = tle_pkg::ST_STAT;
			tle_pkg::ST_STAT: begin
				if (out_free) begin
					state_nxt = tle_pkg::ST_IDLE;
				end
			end
			tle_pkg::ST_LINE_RD: state_nxt = tle_pkg::ST_LINE_LD;
			tle_pkg::ST_LINE_LD: begin
				if (out_free) begin
					state_nxt = (left_q == 6'd1) ? tle_pkg::ST_IDLE : tle_pkg::ST_LINE_RD;
				end
			end
			default:             state_nxt = tle_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory port control, handshake and result loads.
	always_comb begin
		rx_ch.ready = (state_q == tle_pkg::ST_IDLE);
		ram_we      = 1'b0;
		ram_waddr   = dst_q;
		ram_wdata   = ram_rdata;
		ram_raddr   = src_q;
		load_stat   = 1'b0;
		load_char   = 1'b0;
		case (state_q)
			tle_pkg::ST_SHIFT: ram_we = pend_q;
			tle_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = wpos_q;
				ram_wdata = byte_q;
			end
			tle_pkg::ST_STAT:    load_stat = out_free;
			tle_pkg::ST_LINE_RD: ram_raddr = idx_q;
			tle_pkg::ST_LINE_LD: begin
				ram_raddr = idx_q;
				load_char = out_free;
			end
			default: ;
		endcase
	end

	tle_line_ram #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tle_pkg::ST_IDLE;
			phase_q     <= tle_pkg::PH_IDLE;
			cursor_q    <= 6'd0;
			length_q    <= 6'd0;
			max_chars_q <= tle_pkg::MAX_CHARS_RST;
			n_q         <= 6'd0;
			left_q      <= 6'd0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				max_chars_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q  <= dec_phase;
				cursor_q <= dec_cursor;
				length_q <= dec_length;
				pend_q   <= 1'b0;
				left_q   <= length_q;
				if (dec_act == tle_pkg::ACT_INS) begin
					n_q <= length_q - cursor_q;
				end else begin
					// Delete: characters behind the removed one move down by one.
					n_q <= length_q - 6'd1 - dec_cursor;
				end
			end else if (state_q == tle_pkg::ST_SHIFT) begin
				pend_q <= (n_q != 6'd0);
				if (n_q != 6'd0) begin
					n_q <= n_q - 6'd1;
				end
			end
			if (load_char) begin
				left_q <= left_q - 6'd1;
			end
			if (load_stat || load_char) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Shift addresses and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q   <= (dec_act == tle_pkg::ACT_INS);
			empty_q <= (dec_act == tle_pkg::ACT_EMPTY);
			byte_q  <= c;
			wpos_q  <= AW'(cursor_q);
			idx_q   <= '0;
			if (dec_act == tle_pkg::ACT_INS) begin
				src_q <= AW'(length_q) - AW'(1);
			end else begin
				src_q <= AW'(dec_cursor) + AW'(1);
			end
		end else if (state_q == tle_pkg::ST_SHIFT && n_q != 6'd0) begin
			// The entry read now is written one place over in the next cycle.
			if (ins_q) begin
				src_q <= src_q - AW'(1);
				dst_q <= src_q + AW'(1);
			end else begin
				src_q <= src_q + AW'(1);
				dst_q <= src_q - AW'(1);
			end
		end
		if (load_char) begin
			idx_q <= idx_q + AW'(1);
		end
		if (load_stat) begin
			out_kind_q   <= empty_q ? tle_pkg::KIND_EMPTY : tle_pkg::KIND_STATUS;
			out_char_q   <= 8'd0;
			out_cursor_q <= cursor_q;
			out_len_q    <= length_q;
			out_last_q   <= 1'b1;
		end else if (load_char) begin
			out_kind_q   <= tle_pkg::KIND_CHAR;
			out_char_q   <= ram_rdata;
			out_cursor_q <= 6'd0;
			out_len_q    <= 6'd0;
			out_last_q   <= (left_q == 6'd1);
		end
	end

	assign res_ch.valid     = out_valid_q;
	assign res_ch.kind      = out_kind_q;
	assign res_ch.char_out  = out_char_q;
	assign res_ch.caret_pos = out_cursor_q;
	assign res_ch.line_len  = out_len_q;
	assign res_ch.last      = out_last_q;

endmodule

@@ hw/rtl/tle_checker.sv @@
// Port-level checks of the terminal line editor, bound to the top level.
// Depends on tle_pkg and terminal_line_editor_core.
module tle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] kind,
	input logic [7:0] char_out,
	input logic [5:0] caret_pos,
	input logic [5:0] line_len,
	input logic       last
);

	// A status result always ends its byte, carries no character and keeps the cursor in range.
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == tle_pkg::KIND_STATUS |->
			last && char_out == 8'd0 && caret_pos <= line_len)
		else $error("status result malformed");

	// Line output happens after the line is cleared.
	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == tle_pkg::KIND_CHAR || kind == tle_pkg::KIND_EMPTY) |->
			caret_pos == 6'd0 && line_len == 6'd0)
		else $error("line output with nonzero cursor or length");

	// The empty-line marker is a single result.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == tle_pkg::KIND_EMPTY |-> last && char_out == 8'd0)
		else $error("empty-line marker malformed");

	// No unused kind code is ever shown.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> kind == tle_pkg::KIND_STATUS || kind == tle_pkg::KIND_CHAR ||
			kind == tle_pkg::KIND_EMPTY)
		else $error("result kind out of range");

	// A stalled result holds its valid, kind, character and last flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(char_out) &&
			$stable(last))
		else $error("stalled result changed");

endmodule

bind terminal_line_editor_core tle_checker u_tle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_ch.valid),
	.res_ready  (res_ch.ready),
	.kind       (res_ch.kind),
	.char_out   (res_ch.char_out),
	.caret_pos  (res_ch.caret_pos),
	.line_len   (res_ch.line_len),
	.last       (res_ch.last)
);
